// ===== design/bmhq_pkg.sv =====
// Shared types, codes and constants of the binary max-heap priority queue.
package bmhq_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 64;
  localparam int CAP_W         = 11;
  localparam int POS_W         = 11;
  localparam int SLOT_W        = 10;
  localparam int KEY_OUT_W     = 64;
  localparam int KEY_IN_W      = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_DELETE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_POS,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_KEY,
    WR_RDATA,
    WR_PICK
  } wr_sel_e;

  typedef enum logic [2:0] {
    NODE_HOLD,
    NODE_COUNT,
    NODE_ZERO,
    NODE_POS,
    NODE_PARENT,
    NODE_PICK
  } node_sel_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [KEY_IN_W-1:0] key_in;
    logic [POS_W-1:0]           delete_position;
  } bmhq_req_t;

  typedef struct packed {
    status_e                     status;
    logic signed [KEY_OUT_W-1:0] key_out;
    logic [SLOT_W-1:0]           final_slot;
  } bmhq_res_t;

  // controller -> datapath
  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    node_sel_e node_sel;
    logic      key_load_rdata;
    logic      rem_load;
    logic      left_load;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_load;
    status_e   res_status;
    logic      res_key_rem;
    logic      res_slot_node;
  } bmhq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic bad_pos;
    logic idx_last;
    logic moved_lt_rem;
    logic at_root;
    logic parent_lt_key;
    logic no_left;
    logic has_right;
    logic key_lt_pick;
  } bmhq_flags_t;

endpackage

// ===== design/bmhq_ctrl.sv =====
// Sequencer of the heap queue: request decode, sift-up and sift-down walks.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  operation_i,
  input  bmhq_flags_t flags_i,
  output bmhq_cmd_t   cmd_o,
  output logic        busy,
  output logic        res_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EX_ROOT,
    S_EX_LAST,
    S_DL_KEY,
    S_DL_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_C
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       res_valid_q;
  logic       fin;
  status_e    fin_st;
  logic       fin_key;
  logic       fin_slot;
  logic       sift_key;
  logic       sift_slot;

  // sift results: push reports the slot, extract reports key and slot, delete the key
  assign sift_key  = (op_q != OP_PUSH);
  assign sift_slot = (op_q != OP_DELETE);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    fin      = 1'b0;
    fin_st   = ST_OK;
    fin_key  = 1'b0;
    fin_slot = 1'b0;
    cmd_o    = '0;
    cmd_o.rd_sel   = RD_ROOT;
    cmd_o.wr_sel   = WR_KEY;
    cmd_o.node_sel = NODE_HOLD;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          op_d          = operation_i;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        case (op_q)
          OP_PUSH: begin
            if (flags_i.full) begin
              fin    = 1'b1;
              fin_st = ST_FULL;
            end else begin
              cmd_o.node_sel = NODE_COUNT;
              cmd_o.cnt_inc  = 1'b1;
              state_d        = S_UP_RD;
            end
          end
          OP_EXTRACT: begin
            if (flags_i.empty) begin
              fin    = 1'b1;
              fin_st = ST_EMPTY;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ROOT;
              state_d      = S_EX_ROOT;
            end
          end
          OP_DELETE: begin
            if (flags_i.bad_pos) begin
              fin    = 1'b1;
              fin_st = ST_BAD_POS;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = RD_POS;
              cmd_o.node_sel = NODE_POS;
              state_d        = S_DL_KEY;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_EX_ROOT: begin
        cmd_o.rem_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_LAST;
        state_d        = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd_o.key_load_rdata = 1'b1;
        cmd_o.cnt_dec        = 1'b1;
        cmd_o.node_sel       = NODE_ZERO;
        state_d              = S_DN_L;
      end
      S_DL_KEY: begin
        cmd_o.rem_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_LAST;
        state_d        = S_DL_LAST;
      end
      S_DL_LAST: begin
        cmd_o.key_load_rdata = 1'b1;
        cmd_o.cnt_dec        = 1'b1;
        // removing the last entry only shrinks the heap
        if (flags_i.idx_last) begin
          fin     = 1'b1;
          fin_key = 1'b1;
        end else if (flags_i.moved_lt_rem) begin
          state_d = S_DN_L;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (flags_i.at_root) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
          fin          = 1'b1;
          fin_key      = sift_key;
          fin_slot     = sift_slot;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (flags_i.parent_lt_key) begin
          // move the parent down into the hole, advance upward
          cmd_o.wr_sel   = WR_RDATA;
          cmd_o.node_sel = NODE_PARENT;
          state_d        = S_UP_RD;
        end else begin
          cmd_o.wr_sel = WR_KEY;
          fin          = 1'b1;
          fin_key      = sift_key;
          fin_slot     = sift_slot;
        end
      end
      S_DN_L: begin
        if (flags_i.no_left) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
          fin          = 1'b1;
          fin_key      = sift_key;
          fin_slot     = sift_slot;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_DN_R;
        end
      end
      S_DN_R: begin
        cmd_o.left_load = 1'b1;
        cmd_o.rd_en     = flags_i.has_right;
        cmd_o.rd_sel    = RD_RIGHT;
        state_d         = S_DN_C;
      end
      S_DN_C: begin
        cmd_o.wr_en = 1'b1;
        if (flags_i.key_lt_pick) begin
          // move the larger child up into the hole, advance downward
          cmd_o.wr_sel   = WR_PICK;
          cmd_o.node_sel = NODE_PICK;
          state_d        = S_DN_L;
        end else begin
          cmd_o.wr_sel = WR_KEY;
          fin          = 1'b1;
          fin_key      = sift_key;
          fin_slot     = sift_slot;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      cmd_o.res_load      = 1'b1;
      cmd_o.res_status    = fin_st;
      cmd_o.res_key_rem   = fin_key;
      cmd_o.res_slot_node = fin_slot;
      state_d             = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      res_valid_q <= fin;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;

`ifndef SYNTH
  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe without a finished request");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("accepted request did not start work");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_en && cmd_o.wr_en))
    else $error("store read and write in the same cycle");
`endif

endmodule

// ===== design/bmhq_dp.sv =====
// Datapath of the heap queue: key store, hole index, moving key and result register.
module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmhq_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  bmhq_cmd_t        cmd_i,
  output bmhq_flags_t      flags_o,
  output bmhq_res_t        res_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  logic signed [KEY_WIDTH-1:0] mem_q [DEPTH];
  logic signed [KEY_WIDTH-1:0] rdata_q;
  logic signed [KEY_WIDTH-1:0] key_q, rem_q, left_q;
  logic signed [KEY_WIDTH-1:0] pick_val, wr_data;
  logic [IdxW-1:0]             node_q, node_d;
  logic [IdxW-1:0]             rd_addr, last_idx, pos_idx, parent_idx, pick_idx;
  logic [CntW-1:0]             count_q;
  logic [CAP_W-1:0]            cap_q;
  logic [POS_W-1:0]            pos_q;
  logic [CntW:0]               left_c, right_c;
  logic                        right_gt;
  bmhq_res_t                   res_q;

  assign last_idx   = IdxW'(count_q - CntW'(1));
  assign pos_idx    = IdxW'(pos_q - POS_W'(1));
  assign parent_idx = (node_q - IdxW'(1)) >> 1;
  assign left_c     = (CntW + 1)'({node_q, 1'b1});
  assign right_c    = left_c + (CntW + 1)'(1);

  assign flags_o.full          = (CmpW'(count_q) >= CmpW'(cap_q)) ||
                                 (count_q >= CntW'(DEPTH));
  assign flags_o.empty         = (count_q == '0);
  assign flags_o.bad_pos       = (pos_q == '0) || (CmpW'(pos_q) > CmpW'(count_q));
  assign flags_o.idx_last      = (node_q == last_idx);
  assign flags_o.moved_lt_rem  = (rdata_q < rem_q);
  assign flags_o.at_root       = (node_q == '0);
  assign flags_o.parent_lt_key = (rdata_q < key_q);
  assign flags_o.no_left       = (left_c >= (CntW + 1)'(count_q));
  assign flags_o.has_right     = (right_c < (CntW + 1)'(count_q));
  assign flags_o.key_lt_pick   = (key_q < pick_val);

  // left wins unless the right child exists and is strictly greater
  assign right_gt = flags_o.has_right && (left_q < rdata_q);
  assign pick_val = right_gt ? rdata_q : left_q;
  assign pick_idx = right_gt ? right_c[IdxW-1:0] : left_c[IdxW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = last_idx;
      RD_POS:    rd_addr = pos_idx;
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = left_c[IdxW-1:0];
      RD_RIGHT:  rd_addr = right_c[IdxW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_KEY:   wr_data = key_q;
      WR_RDATA: wr_data = rdata_q;
      WR_PICK:  wr_data = pick_val;
      default:  wr_data = key_q;
    endcase
  end

  always_comb begin
    case (cmd_i.node_sel)
      NODE_HOLD:   node_d = node_q;
      NODE_COUNT:  node_d = IdxW'(count_q);
      NODE_ZERO:   node_d = '0;
      NODE_POS:    node_d = pos_idx;
      NODE_PARENT: node_d = parent_idx;
      NODE_PICK:   node_d = pick_idx;
      default:     node_d = node_q;
    endcase
  end

  // key store, write at the hole, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[node_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    if (cmd_i.load_in) begin
      key_q <= req_i.key_in[KEY_WIDTH-1:0];
      pos_q <= req_i.delete_position;
    end else if (cmd_i.key_load_rdata) begin
      key_q <= rdata_q;
    end
    if (cmd_i.rem_load) begin
      rem_q <= rdata_q;
    end
    if (cmd_i.left_load) begin
      left_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      res_q.status     <= cmd_i.res_status;
      res_q.key_out    <= cmd_i.res_key_rem ? KEY_OUT_W'(rem_q) : '0;
      res_q.final_slot <= cmd_i.res_slot_node ? SLOT_W'(node_q) : '0;
    end
  end

  assign res_o = res_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond store depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> (count_q == CntW'($past(count_q) + CntW'(1))))
    else $error("entry count did not advance on push");
`endif

endmodule

// ===== design/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue.
//
//   port group                   dir  handshake               contents
//   start/busy, req_i            in   start && !busy          operation, key, position
//   res_valid_o, res_o           out  one-cycle strobe        status, key, slot
//   cfg_valid_i/ready_o, data    in   valid && ready          capacity limit
//
// The moving entry travels at most log2(DEPTH) levels. Errors and unused codes finish
// in the check state; delete of the last entry only shrinks the heap; push sifts up,
// delete moves the last entry up or down from the hole, and extract sifts down.
// Each level reads the store once going up (the parent) and, going down, the left
// child and then the right child if it exists, since the store has one port with
// registered read data.
// busy drops in the cycle the result is shown; a new request may start then.
// Results cannot be held off; requests stall only while busy is high.
// Reset clears the entry count and sets the capacity limit to 1024; store needs no clearing.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bmhq_req_t        req_i,
  output logic             res_valid_o,
  output bmhq_res_t        res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  bmhq_cmd_t   cmd;
  bmhq_flags_t flags;

  assign cfg_ready_o = ~busy;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (req_i.operation),
    .flags_i     (flags),
    .cmd_o       (cmd),
    .busy        (busy),
    .res_valid_o (res_valid_o)
  );

  bmhq_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .flags_o    (flags),
    .res_o      (res_o)
  );

endmodule

// ===== verif/binary_max_heap_queue_tb.sv =====
// Self-checking testbench for the binary max-heap priority queue.
module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  typedef logic signed [KEY_IN_W-1:0] key_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam key_t KEY_MAX = {1'b0, {(KEY_IN_W-1){1'b1}}};
  localparam key_t KEY_MIN = {1'b1, {(KEY_IN_W-1){1'b0}}};
  localparam int DRAIN_CYCLES = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  bmhq_req_t        req_i;
  logic             res_valid_o;
  bmhq_res_t        res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;

  binary_max_heap_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Predicted heap contents and registers
  key_t             heap_mem [DEPTH_DEF];
  int unsigned      heap_count;
  logic [CAP_W-1:0] cap_model;

  bmhq_res_t awaited_res_q[$];
  bmhq_res_t want;
  int        mismatch_count;
  int        burst_left;
  int        n_push, n_extract, n_delete, n_unused, n_cfg, n_checked;
  int        n_full, n_empty, n_bad_pos, peak_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("binary_max_heap_queue verification failed");
    $finish;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    key_t t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic int unsigned sift_up_slot(int unsigned node);
    int unsigned parent;
    while (node > 0) begin
      parent = (node - 1) / 2;
      if (!(heap_mem[parent] < heap_mem[node])) break;
      swap_slots(parent, node);
      node = parent;
    end
    return node;
  endfunction

  // Left child wins ties; swap only on a strictly greater child
  function automatic int unsigned sift_down_slot(int unsigned node);
    int unsigned left, right, pick;
    forever begin
      left  = 2 * node + 1;
      right = left + 1;
      if (left >= heap_count) break;
      pick = left;
      if (right < heap_count && heap_mem[left] < heap_mem[right]) pick = right;
      if (!(heap_mem[node] < heap_mem[pick])) break;
      swap_slots(pick, node);
      node = pick;
    end
    return node;
  endfunction

  function automatic bmhq_res_t heap_apply(bmhq_req_t r);
    bmhq_res_t   res;
    int unsigned limit, idx, last;
    res   = '0;
    limit = (cap_model < DEPTH_DEF) ? cap_model : DEPTH_DEF;
    case (r.operation)
      OP_PUSH: begin
        if (heap_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          heap_mem[heap_count] = r.key_in;
          heap_count++;
          res.final_slot = SLOT_W'(sift_up_slot(heap_count - 1));
        end
      end
      OP_EXTRACT: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          last        = heap_count - 1;
          res.key_out = heap_mem[0];
          swap_slots(0, last);
          heap_count     = last;
          res.final_slot = SLOT_W'(sift_down_slot(0));
        end
      end
      OP_DELETE: begin
        if (r.delete_position == 0 || r.delete_position > heap_count) begin
          res.status = ST_BAD_POS;
        end else begin
          idx         = r.delete_position - 1;
          last        = heap_count - 1;
          res.key_out = heap_mem[idx];
          swap_slots(idx, last);
          heap_count = last;
          // moved entry goes down if smaller than the removed key, else up
          if (idx != last) begin
            if (heap_mem[idx] < res.key_out) void'(sift_down_slot(idx));
            else void'(sift_up_slot(idx));
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bmhq_req_t mk_req(logic [1:0] op, key_t k, logic [POS_W-1:0] p);
    bmhq_req_t r;
    r.operation       = op;
    r.key_in          = k;
    r.delete_position = p;
    return r;
  endfunction

  // Favor extremes and a narrow band of values so equal keys are common
  function automatic key_t rand_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2:       return key_t'($urandom_range(0, 1)) - 1;
      3, 4, 5: return key_t'($urandom_range(0, 7)) - 4;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'(heap_count + 1);
      2:       return POS_W'($urandom_range(0, 2047));
      default: return POS_W'((heap_count == 0) ? 1 : $urandom_range(1, heap_count));
    endcase
  endfunction

  function automatic bmhq_req_t rand_req(int push_pct);
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(0, 99);
    if (roll >= 96) op = OP_UNUSED;
    else if (roll < push_pct) op = OP_PUSH;
    else if (roll < (push_pct + 96) / 2) op = OP_EXTRACT;
    else op = OP_DELETE;
    return mk_req(op, rand_key(), rand_pos());
  endfunction

  // Present one request; start is left high after acceptance for back-to-back issue
  task automatic send_req(input bmhq_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8);
      if (gap > 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    awaited_res_q.push_back(heap_apply(r));
    case (r.operation)
      OP_PUSH:    n_push++;
      OP_EXTRACT: n_extract++;
      OP_DELETE:  n_delete++;
      default:    n_unused++;
    endcase
    if (heap_count > peak_count) peak_count = heap_count;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (awaited_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_model = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_empty_heap();
    send_req(mk_req(OP_EXTRACT, '0, '0));
    send_req(mk_req(OP_DELETE, '0, POS_W'(1)));
    send_req(mk_req(OP_UNUSED, KEY_MAX, '1));
  endtask

  task automatic test_key_extremes();
    send_req(mk_req(OP_PUSH, KEY_MAX, '0));
    send_req(mk_req(OP_PUSH, KEY_MIN, '0));
    send_req(mk_req(OP_PUSH, '0, '0));
    send_req(mk_req(OP_PUSH, '1, '1));
    send_req(mk_req(OP_PUSH, KEY_MAX, '0));
    send_req(mk_req(OP_PUSH, key_t'(5), '0));
    send_req(mk_req(OP_DELETE, '0, '0));
    send_req(mk_req(OP_DELETE, '0, POS_W'(heap_count + 1)));
    send_req(mk_req(OP_DELETE, '0, '1));
    // last entry: shrink only
    send_req(mk_req(OP_DELETE, '0, POS_W'(heap_count)));
    send_req(mk_req(OP_DELETE, '0, POS_W'(2)));
    send_req(mk_req(OP_EXTRACT, '1, '0));
    send_req(mk_req(OP_EXTRACT, '0, '1));
  endtask

  task automatic test_capacity_edges();
    drain();
    write_capacity('0);
    send_req(mk_req(OP_PUSH, key_t'(1), '0));
    drain();
    // limit below current count
    write_capacity(CAP_W'(1));
    send_req(mk_req(OP_PUSH, key_t'(2), '0));
    send_req(mk_req(OP_EXTRACT, '0, '0));
    send_req(mk_req(OP_EXTRACT, '0, '0));
    send_req(mk_req(OP_PUSH, KEY_MIN, '0));
    send_req(mk_req(OP_PUSH, KEY_MAX, '0));
    drain();
    write_capacity('1);
    send_req(mk_req(OP_PUSH, KEY_MAX, '0));
  endtask

  task automatic test_small_capacity();
    int caps [4] = '{1, 2, 3, 5};
    foreach (caps[i]) begin
      drain();
      write_capacity(CAP_W'(caps[i]));
      repeat (90) send_req(rand_req(55));
    end
  endtask

  task automatic test_full_heap();
    drain();
    // beyond depth: effective limit is the store size
    write_capacity('1);
    while (heap_count < DEPTH_DEF) send_req(mk_req(OP_PUSH, rand_key(), rand_pos()));
    repeat (4) send_req(mk_req(OP_PUSH, rand_key(), rand_pos()));
    repeat (100) send_req(rand_req(30));
    drain();
    write_capacity(CAP_W'(16));
    repeat (30) send_req(rand_req(50));
    drain();
    write_capacity(CAP_RESET);
    repeat (20) send_req(rand_req(50));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (awaited_res_q.size() == 0) begin
        $display("%0t: unexpected result status %0d key %0d slot %0d",
                 $time, res_o.status, res_o.key_out, res_o.final_slot);
        mismatch_count++;
      end else begin
        want = awaited_res_q.pop_front();
        n_checked++;
        case (want.status)
          ST_FULL:    n_full++;
          ST_EMPTY:   n_empty++;
          ST_BAD_POS: n_bad_pos++;
          default:    ;
        endcase
        if (res_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res_o.status);
          mismatch_count++;
        end
        if (res_o.key_out !== want.key_out) begin
          $display("%0t: key_out expected %0d got %0d", $time, want.key_out, res_o.key_out);
          mismatch_count++;
        end
        if (res_o.final_slot !== want.final_slot) begin
          $display("%0t: final_slot expected %0d got %0d",
                   $time, want.final_slot, res_o.final_slot);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    heap_count  = 0;
    cap_model   = CAP_RESET;
    burst_left  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_heap();
    test_key_extremes();
    test_capacity_edges();
    test_small_capacity();
    test_full_heap();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d push, %0d extract, %0d delete, %0d unused code",
             n_push + n_extract + n_delete + n_unused, n_push, n_extract, n_delete,
             n_unused);
    $display("Checked %0d results (%0d full, %0d empty, %0d bad position), "
             , n_checked, n_full, n_empty, n_bad_pos,
             "peak occupancy %0d, %0d capacity writes", peak_count, n_cfg);
    if (mismatch_count == 0) begin
      $display("binary_max_heap_queue verification clean");
    end else begin
      $display("binary_max_heap_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== binary_max_heap_queue.f =====
design/bmhq_pkg.sv
design/bmhq_ctrl.sv
design/bmhq_dp.sv
design/binary_max_heap_queue.sv
verif/binary_max_heap_queue_tb.sv
